// ===== design/ogcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogcm_pkg
// Shared types, constants and helpers for the occupancy grid coarse map update.
// ----------------------------------------------------------------------------
package ogcm_pkg;

   localparam int FINE_WIDTH_DEF  = 96;
   localparam int FINE_HEIGHT_DEF = 96;

   localparam int COORD_W  = 7;   // fine coordinate width
   localparam int CRS_W    = 6;   // coarse coordinate width
   localparam int WROW_W   = 8;   // fine row index in the window scan
   localparam int CELL_W   = 8;
   localparam int COUNT_W  = 4;

   localparam logic [CELL_W-1:0] WALL_VAL  = 8'd255;
   localparam logic [CELL_W-1:0] FREED_VAL = 8'd254;

   typedef enum logic {
      CMD_SET   = 1'b0,
      CMD_CLEAR = 1'b1
   } req_cmd_type;

   typedef enum logic [1:0] {
      ST_CHANGED = 2'd0,
      ST_SAME    = 2'd1,
      ST_OUTSIDE = 2'd2
   } rsp_status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_FRD,
      S_FCHK,
      S_WIN,
      S_CRD,
      S_CWR,
      S_RESP
   } ctl_state_type;

   typedef struct packed {
      logic           init_step;
      logic           capture;
      logic           fine_rd;
      logic           fine_wr;
      logic           win_init;
      logic           win_step;
      logic           crs_rd;
      logic           crs_wr;
      logic           crow_sel;
      logic           status_ld;
      rsp_status_type status_code;
      logic           rsp_load;
   } ogcm_cmd_type;

   typedef struct packed {
      logic init_done;
      logic in_grid;
      logic bit_same;
      logic is_set;
      logic win_done;
      logic row1_valid;
      logic rsp_busy;
   } ogcm_sts_type;

   // floor(v / 3) for a fine coordinate
   function automatic logic [CRS_W-1:0] div3(input logic [COORD_W-1:0] v);
      logic [15:0] prod;
      prod = {9'b0, v} * 16'd171;
      return prod[14:9];
   endfunction

   function automatic logic [7:0] times3(input logic [CRS_W-1:0] c);
      return {2'b00, c} + {1'b0, c, 1'b0};
   endfunction

endpackage

// ===== design/ogcm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogcm_ctrl
// Sequencer: memory clear pass, fine pixel update, window scan, coarse update.
// ----------------------------------------------------------------------------
module ogcm_ctrl
   import ogcm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ogcm_sts_type sts,
   output ogcm_cmd_type cmd
);

   ctl_state_type state_ff, state_in;
   logic          row_sel_ff, row_sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_INIT;
         row_sel_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         row_sel_ff <= row_sel_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      row_sel_in     = row_sel_ff;
      cmd            = '0;
      cmd.crow_sel   = row_sel_ff;
      req_ready      = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (sts.init_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            row_sel_in  = 1'b0;
            if (req_valid) begin
               state_in = S_FRD;
            end
         end
         S_FRD: begin
            if (!sts.in_grid) begin
               cmd.status_ld   = 1'b1;
               cmd.status_code = ST_OUTSIDE;
               state_in        = S_RESP;
            end else begin
               cmd.fine_rd = 1'b1;
               state_in    = S_FCHK;
            end
         end
         S_FCHK: begin
            cmd.status_ld = 1'b1;
            if (sts.bit_same) begin
               cmd.status_code = ST_SAME;
               state_in        = S_RESP;
            end else begin
               cmd.status_code = ST_CHANGED;
               cmd.fine_wr     = 1'b1;
               if (sts.is_set) begin
                  state_in = S_CRD;
               end else begin
                  cmd.win_init = 1'b1;
                  state_in     = S_WIN;
               end
            end
         end
         S_WIN: begin
            cmd.win_step = 1'b1;
            if (sts.win_done) begin
               state_in = S_CRD;
            end
         end
         S_CRD: begin
            cmd.crs_rd = 1'b1;
            state_in   = S_CWR;
         end
         S_CWR: begin
            cmd.crs_wr = 1'b1;
            if (!row_sel_ff && sts.row1_valid) begin
               row_sel_in = 1'b1;
               state_in   = S_CRD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

endmodule

// ===== design/ogcm_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogcm_dpath
// Fine and coarse map memories, coordinate decode, window scan and output
// register.
// ----------------------------------------------------------------------------
module ogcm_dpath
   import ogcm_pkg::*;
#(
   parameter int FINE_WIDTH  = FINE_WIDTH_DEF,
   parameter int FINE_HEIGHT = FINE_HEIGHT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ogcm_cmd_type         cmd,
   output ogcm_sts_type         sts,
   input  logic                 req_cmd,
   input  logic [COORD_W-1:0]   req_fine_x,
   input  logic [COORD_W-1:0]   req_fine_y,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [COUNT_W-1:0]   rsp_coarse_changed_count,
   output logic                 rsp_path_update
);

   localparam int COARSE_W  = (FINE_WIDTH + 2) / 3;
   localparam int COARSE_H  = (FINE_HEIGHT + 2) / 3;
   localparam int ROW_AW    = $clog2(FINE_HEIGHT);
   localparam int COL_AW    = $clog2(FINE_WIDTH);
   localparam int CROW_AW   = (COARSE_H > 1) ? $clog2(COARSE_H) : 1;
   localparam int CROW_BITS = COARSE_W * CELL_W;
   localparam int CROW_IW   = $clog2(CROW_BITS);
   localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(FINE_HEIGHT - 1);

   // memories
   logic [FINE_WIDTH-1:0] fine_mem [FINE_HEIGHT];
   logic [CROW_BITS-1:0]  crs_mem  [COARSE_H];

   // registers
   req_cmd_type          cmd_ff;
   logic [COORD_W-1:0]   x_ff, y_ff;
   rsp_status_type       status_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [3:0]           busy_ff;
   logic [WROW_W-1:0]    r_ff;
   logic                 win_rd_ff;
   logic [WROW_W-1:0]    win_tag_ff;
   logic [ROW_AW-1:0]    clr_ff;
   logic [FINE_WIDTH-1:0] fine_q_ff;
   logic [CROW_BITS-1:0] crs_q_ff;
   logic                 rsp_valid_ff;
   rsp_status_type       rsp_status_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 rsp_path_ff;

   // decode
   logic [CRS_W-1:0]     cx, cy, col1, row1, rmin, rmax, cur_row;
   logic [7:0]           tx, ty;
   logic [1:0]           mx, my;
   logic                 col1_v, row1_v, in_grid;
   logic [WROW_W-1:0]    wlo, whi, whi_raw;
   logic                 win_issue;
   logic [CRS_W-1:0]     col_sel [2];
   logic [CRS_W-1:0]     row_sel [2];
   logic [7:0]           base;
   logic [8:0]           pos;
   logic [1:0]           occ, inwin;
   logic [3:0]           busy_hit;
   logic [CELL_W-1:0]    crs_cell [2];
   logic [1:0]           hit;
   logic [1:0]           n_hits;
   logic [CROW_BITS-1:0] crs_wd;
   logic [FINE_WIDTH-1:0] fine_wd;

   // memory port controls
   logic                 fine_we, fine_re, crs_we;
   logic [ROW_AW-1:0]    fine_wa, fine_ra;
   logic [FINE_WIDTH-1:0] fine_wdata;
   logic [CROW_AW-1:0]   crs_wa, crs_ra;
   logic [CROW_BITS-1:0] crs_wdata;

   always_comb begin
      cx      = div3(x_ff);
      cy      = div3(y_ff);
      tx      = times3(cx);
      ty      = times3(cy);
      mx      = 2'(x_ff - tx[COORD_W-1:0]);
      my      = 2'(y_ff - ty[COORD_W-1:0]);
      col1    = (mx == 2'd0) ? cx - 6'd1 : cx + 6'd1;
      row1    = (my == 2'd0) ? cy - 6'd1 : cy + 6'd1;
      col1_v  = ((mx == 2'd0) && (cx != '0)) ||
                ((mx == 2'd2) && (int'(cx) + 1 < COARSE_W));
      row1_v  = ((my == 2'd0) && (cy != '0)) ||
                ((my == 2'd2) && (int'(cy) + 1 < COARSE_H));
      in_grid = (int'(x_ff) < FINE_WIDTH) && (int'(y_ff) < FINE_HEIGHT);
      rmin    = (row1_v && (my == 2'd0)) ? row1 : cy;
      rmax    = (row1_v && (my == 2'd2)) ? row1 : cy;
      wlo     = (rmin == '0) ? '0 : times3(rmin) - 8'd1;
      whi_raw = times3(rmax) + 8'd3;
      whi     = (int'(whi_raw) > FINE_HEIGHT - 1) ? WROW_W'(FINE_HEIGHT - 1) : whi_raw;
      win_issue  = (r_ff <= whi);
      col_sel[0] = cx;
      col_sel[1] = col1;
      row_sel[0] = cy;
      row_sel[1] = row1;
      cur_row    = cmd.crow_sel ? row1 : cy;
   end

   // window scan: occupancy of each candidate column slice in the returned row
   always_comb begin
      occ   = '0;
      inwin = '0;
      base  = '0;
      pos   = '0;
      for (int k = 0; k < 2; k++) begin
         base = times3(col_sel[k]);
         for (int i = 0; i < 5; i++) begin
            pos = {1'b0, base} + 9'(i);
            if ((pos != '0) && (int'(pos) <= FINE_WIDTH)) begin
               occ[k] = occ[k] | fine_q_ff[COL_AW'(pos - 9'd1)];
            end
         end
      end
      for (int j = 0; j < 2; j++) begin
         inwin[j] = (({1'b0, win_tag_ff} + 9'd1) >= {1'b0, times3(row_sel[j])}) &&
                    (win_tag_ff <= (times3(row_sel[j]) + 8'd3));
      end
      for (int j = 0; j < 2; j++) begin
         for (int k = 0; k < 2; k++) begin
            busy_hit[2*j+k] = win_rd_ff & occ[k] & inwin[j];
         end
      end
   end

   // coarse row update
   always_comb begin
      crs_wd = crs_q_ff;
      hit    = '0;
      for (int k = 0; k < 2; k++) begin
         crs_cell[k] = crs_q_ff[CROW_IW'(col_sel[k]*CELL_W) +: CELL_W];
         if ((k == 0) || col1_v) begin
            if (cmd_ff == CMD_SET) begin
               hit[k] = (crs_cell[k] != WALL_VAL);
            end else begin
               hit[k] = (crs_cell[k] == WALL_VAL) && !busy_ff[{cmd.crow_sel, 1'(k)}];
            end
         end
         if (hit[k]) begin
            crs_wd[CROW_IW'(col_sel[k]*CELL_W) +: CELL_W] =
               (cmd_ff == CMD_SET) ? WALL_VAL : FREED_VAL;
         end
      end
      n_hits = {1'b0, hit[0]} + {1'b0, hit[1]};
   end

   always_comb begin
      fine_wd                = fine_q_ff;
      fine_wd[COL_AW'(x_ff)] = (cmd_ff == CMD_SET);
      fine_we    = cmd.init_step | cmd.fine_wr;
      fine_wa    = cmd.init_step ? clr_ff : ROW_AW'(y_ff);
      fine_wdata = cmd.init_step ? '0 : fine_wd;
      fine_re    = cmd.fine_rd | (cmd.win_step & win_issue);
      fine_ra    = cmd.win_step ? ROW_AW'(r_ff) : ROW_AW'(y_ff);
      crs_we     = (cmd.init_step && (int'(clr_ff) < COARSE_H)) || cmd.crs_wr;
      crs_wa     = cmd.init_step ? CROW_AW'(clr_ff) : CROW_AW'(cur_row);
      crs_wdata  = cmd.init_step ? '0 : crs_wd;
      crs_ra     = CROW_AW'(cur_row);
   end

   always_ff @(posedge clock) begin
      if (fine_we) begin
         fine_mem[fine_wa] <= fine_wdata;
      end
      if (fine_re) begin
         fine_q_ff <= fine_mem[fine_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (crs_we) begin
         crs_mem[crs_wa] <= crs_wdata;
      end
      if (cmd.crs_rd) begin
         crs_q_ff <= crs_mem[crs_ra];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         r_ff         <= '0;
         win_rd_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.init_step && (clr_ff != ROW_LAST)) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.win_init) begin
            r_ff      <= wlo;
            win_rd_ff <= 1'b0;
         end else if (cmd.win_step) begin
            win_rd_ff <= win_issue;
            if (win_issue) begin
               r_ff <= r_ff + 1'b1;
            end
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= req_cmd_type'(req_cmd);
         x_ff     <= req_fine_x;
         y_ff     <= req_fine_y;
         count_ff <= '0;
         busy_ff  <= '0;
      end
      if (cmd.win_step) begin
         busy_ff    <= busy_ff | busy_hit;
         win_tag_ff <= r_ff;
      end
      if (cmd.crs_wr) begin
         count_ff <= count_ff + COUNT_W'(n_hits);
      end
      if (cmd.status_ld) begin
         status_ff <= cmd.status_code;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
         rsp_path_ff   <= (count_ff != '0);
      end
   end

   always_comb begin
      sts.init_done  = (clr_ff == ROW_LAST);
      sts.in_grid    = in_grid;
      sts.bit_same   = (fine_q_ff[COL_AW'(x_ff)] == (cmd_ff == CMD_SET));
      sts.is_set     = (cmd_ff == CMD_SET);
      sts.win_done   = !win_issue && !win_rd_ff;
      sts.row1_valid = row1_v;
      sts.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_status               = rsp_status_ff;
   assign rsp_coarse_changed_count = rsp_count_ff;
   assign rsp_path_update          = rsp_path_ff;

endmodule

// ===== design/occupancy_grid_coarse_map_update.sv =====
// A clear command adds a window scan of up to eight fine rows, one row per memory
// read, before the coarse update.
// Throughput: one item at a time, next transfer the cycle after the result is
// registered; a pending result does not block a new transfer.
// Reset: a clear pass writes one fine row per cycle, and a coarse row beside each
// of the first COARSE_H, with req_ready low.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_coarse_map_update
// Fine binary occupancy grid with a coarse wall map, one cell per 3x3 block.
// ----------------------------------------------------------------------------
module occupancy_grid_coarse_map_update
   import ogcm_pkg::*;
#(
   parameter int FINE_WIDTH  = FINE_WIDTH_DEF,
   parameter int FINE_HEIGHT = FINE_HEIGHT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [COORD_W-1:0] req_fine_x,
   input  logic [COORD_W-1:0] req_fine_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [COUNT_W-1:0] rsp_coarse_changed_count,
   output logic               rsp_path_update
);

   ogcm_cmd_type cmd;
   ogcm_sts_type sts;

   ogcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ogcm_dpath #(
      .FINE_WIDTH  (FINE_WIDTH),
      .FINE_HEIGHT (FINE_HEIGHT)
   ) u_dpath (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .sts                      (sts),
      .req_cmd                  (req_cmd),
      .req_fine_x               (req_fine_x),
      .req_fine_y               (req_fine_y),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_status               (rsp_status),
      .rsp_coarse_changed_count (rsp_coarse_changed_count),
      .rsp_path_update          (rsp_path_update)
   );

endmodule
